// File: design/mpct_pkg.sv
// Shared types, codes and constants of the mouse packet cursor tracker.
// No dependencies; every other design file imports this package.
package mpct_pkg;

    // Default coordinate width of the cursor outputs
    localparam int COORD_BITS_DEF = 12;

    // Configuration field widths
    localparam int SPEED_W = 2;
    localparam int SIZE_W  = 12;

    // Screen size used when a size register holds zero
    localparam logic [SIZE_W-1:0] DEFAULT_W = 12'd800;
    localparam logic [SIZE_W-1:0] DEFAULT_H = 12'd600;

    // Cursor position after reset
    localparam int RESET_X = 400;
    localparam int RESET_Y = 300;

    // Flags byte bit positions
    localparam int BIT_LEFT   = 0;
    localparam int BIT_RIGHT  = 1;
    localparam int BIT_SYNC   = 3;
    localparam int BIT_X_SIGN = 4;
    localparam int BIT_Y_SIGN = 5;
    localparam int BIT_X_OVF  = 6;
    localparam int BIT_Y_OVF  = 7;

    // Input operation codes
    typedef enum logic {
        OP_BYTE     = 1'b0,
        OP_RECENTER = 1'b1
    } t_op;

    // Result status codes
    typedef enum logic [1:0] {
        ST_NONE     = 2'd0,
        ST_APPLIED  = 2'd1,
        ST_REJECTED = 2'd2
    } t_status;

    // Configuration register indexes
    typedef enum logic [1:0] {
        CFG_SPEED  = 2'd0,
        CFG_WIDTH  = 2'd1,
        CFG_HEIGHT = 2'd2
    } t_cfg_idx;

    // Speed modes; the unused code behaves as normal speed
    localparam logic [SPEED_W-1:0] SPEED_HALF   = 2'd0;
    localparam logic [SPEED_W-1:0] SPEED_NORMAL = 2'd1;
    localparam logic [SPEED_W-1:0] SPEED_DOUBLE = 2'd2;

    // Scale a 9-bit signed movement; halving truncates toward zero
    function automatic logic signed [9:0] scale_move(
        input logic signed [8:0]        d,
        input logic [SPEED_W-1:0]       speed
    );
        logic signed [9:0] d10;
        logic signed [9:0] res;
        d10 = 10'(d);
        unique case (speed)
            SPEED_HALF: begin
                if (d[8]) begin
                    d10 = d10 + 10'sd1;
                end
                res = d10 >>> 1;
            end
            SPEED_DOUBLE: res = d10 <<< 1;
            default:      res = d10;
        endcase
        return res;
    endfunction

endpackage

// File: design/mpct_cfg.sv
// Configuration registers of the mouse packet cursor tracker and the
// effective screen limits derived from them. Depends on mpct_pkg.
module mpct_cfg #(
    parameter int COORD_BITS = mpct_pkg::COORD_BITS_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_cfg_valid,
    output logic                        o_cfg_ready,
    input  logic [1:0]                  i_cfg_index,
    input  logic [mpct_pkg::SIZE_W-1:0] i_cfg_data,
    output logic [mpct_pkg::SPEED_W-1:0] o_speed,
    output logic [COORD_BITS:0]         o_lim_x,
    output logic [COORD_BITS:0]         o_lim_y
);
    import mpct_pkg::*;

    localparam logic [31:0] LIM_MAX = 32'd1 << COORD_BITS;

    logic [SPEED_W-1:0] r_speed;
    logic [SIZE_W-1:0]  r_width;
    logic [SIZE_W-1:0]  r_height;
    logic [SIZE_W-1:0]  w_eff_w;
    logic [SIZE_W-1:0]  w_eff_h;

    // Always take register writes
    assign o_cfg_ready = 1'b1;

    // Write the addressed register; drop writes beyond the list
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_speed  <= SPEED_NORMAL;
            r_width  <= DEFAULT_W;
            r_height <= DEFAULT_H;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_SPEED:  r_speed  <= i_cfg_data[SPEED_W-1:0];
                CFG_WIDTH:  r_width  <= i_cfg_data;
                CFG_HEIGHT: r_height <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Substitute the default size for zero, then cap at the coordinate range
    assign w_eff_w = (r_width  == '0) ? DEFAULT_W : r_width;
    assign w_eff_h = (r_height == '0) ? DEFAULT_H : r_height;

    always_comb begin
        if (32'(w_eff_w) > LIM_MAX) begin
            o_lim_x = LIM_MAX[COORD_BITS:0];
        end else begin
            o_lim_x = (COORD_BITS+1)'(w_eff_w);
        end
        if (32'(w_eff_h) > LIM_MAX) begin
            o_lim_y = LIM_MAX[COORD_BITS:0];
        end else begin
            o_lim_y = (COORD_BITS+1)'(w_eff_h);
        end
    end

    assign o_speed = r_speed;

endmodule

// File: design/mpct_tracker.sv
// Packet assembly and cursor state of the mouse packet cursor tracker.
// Computes the result of one transaction and updates state when it is taken.
// Depends on mpct_pkg.
module mpct_tracker #(
    parameter int COORD_BITS = mpct_pkg::COORD_BITS_DEF
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_take,
    input  logic                         i_operation,
    input  logic                         i_aux_ready,
    input  logic [7:0]                   i_data_byte,
    input  logic [mpct_pkg::SPEED_W-1:0] i_speed,
    input  logic [COORD_BITS:0]          i_lim_x,
    input  logic [COORD_BITS:0]          i_lim_y,
    output logic [COORD_BITS-1:0]        o_cursor_x,
    output logic [COORD_BITS-1:0]        o_cursor_y,
    output logic                         o_left_button,
    output logic                         o_right_button,
    output mpct_pkg::t_status            o_packet_status
);
    import mpct_pkg::*;

    localparam int SW = COORD_BITS + 2;

    logic [1:0]             r_phase,  n_phase;
    logic [7:0]             r_held0,  n_held0;
    logic [7:0]             r_held1,  n_held1;
    logic [COORD_BITS-1:0]  r_pos_x,  n_pos_x;
    logic [COORD_BITS-1:0]  r_pos_y,  n_pos_y;
    logic                   r_left,   n_left;
    logic                   r_right,  n_right;
    t_status                w_status;

    logic                   w_reject;
    logic signed [8:0]      w_dx9;
    logic signed [8:0]      w_dy9;
    logic signed [9:0]      w_dx;
    logic signed [9:0]      w_dy;
    logic signed [SW-1:0]   w_sum_x;
    logic signed [SW-1:0]   w_sum_y;
    logic signed [SW-1:0]   w_lim_x;
    logic signed [SW-1:0]   w_lim_y;
    logic [COORD_BITS-1:0]  w_clamp_x;
    logic [COORD_BITS-1:0]  w_clamp_y;

    // Validate the packet and build signed 9-bit movements from the flags
    assign w_reject = !r_held0[BIT_SYNC] || r_held0[BIT_X_OVF] || r_held0[BIT_Y_OVF];
    assign w_dx9    = $signed({r_held0[BIT_X_SIGN], r_held1});
    assign w_dy9    = $signed({r_held0[BIT_Y_SIGN], i_data_byte});
    assign w_dx     = scale_move(w_dx9, i_speed);
    assign w_dy     = scale_move(w_dy9, i_speed);

    // Move the cursor; screen Y grows downward
    assign w_sum_x = $signed({2'b00, r_pos_x}) + SW'(w_dx);
    assign w_sum_y = $signed({2'b00, r_pos_y}) - SW'(w_dy);
    assign w_lim_x = $signed({1'b0, i_lim_x});
    assign w_lim_y = $signed({1'b0, i_lim_y});

    // Clamp to the screen
    always_comb begin
        if (w_sum_x < 0) begin
            w_clamp_x = '0;
        end else if (w_sum_x >= w_lim_x) begin
            w_clamp_x = COORD_BITS'(i_lim_x - 1'b1);
        end else begin
            w_clamp_x = w_sum_x[COORD_BITS-1:0];
        end
        if (w_sum_y < 0) begin
            w_clamp_y = '0;
        end else if (w_sum_y >= w_lim_y) begin
            w_clamp_y = COORD_BITS'(i_lim_y - 1'b1);
        end else begin
            w_clamp_y = w_sum_y[COORD_BITS-1:0];
        end
    end

    // Next state and status for the transaction in hand
    always_comb begin
        n_phase  = r_phase;
        n_held0  = r_held0;
        n_held1  = r_held1;
        n_pos_x  = r_pos_x;
        n_pos_y  = r_pos_y;
        n_left   = r_left;
        n_right  = r_right;
        w_status = ST_NONE;
        priority if (i_operation == OP_RECENTER) begin
            n_pos_x = i_lim_x[COORD_BITS:1];
            n_pos_y = i_lim_y[COORD_BITS:1];
            n_left  = 1'b0;
            n_right = 1'b0;
            n_phase = 2'd0;
            n_held0 = '0;
            n_held1 = '0;
        end else if (i_aux_ready) begin
            if (r_phase == 2'd0) begin
                n_held0 = i_data_byte;
                n_phase = 2'd1;
            end else if (r_phase == 2'd1) begin
                n_held1 = i_data_byte;
                n_phase = 2'd2;
            end else begin
                n_phase = 2'd0;
                if (w_reject) begin
                    w_status = ST_REJECTED;
                end else begin
                    w_status = ST_APPLIED;
                    n_pos_x  = w_clamp_x;
                    n_pos_y  = w_clamp_y;
                    n_left   = r_held0[BIT_LEFT];
                    n_right  = r_held0[BIT_RIGHT];
                end
            end
        end else begin
            // Ignore bytes that do not come from the mouse
        end
    end

    // Commit state when the transaction moves to the result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= '0;
            r_held0 <= '0;
            r_held1 <= '0;
            r_pos_x <= COORD_BITS'(RESET_X);
            r_pos_y <= COORD_BITS'(RESET_Y);
            r_left  <= 1'b0;
            r_right <= 1'b0;
        end else if (i_take) begin
            r_phase <= n_phase;
            r_held0 <= n_held0;
            r_held1 <= n_held1;
            r_pos_x <= n_pos_x;
            r_pos_y <= n_pos_y;
            r_left  <= n_left;
            r_right <= n_right;
        end
    end

    assign o_cursor_x      = n_pos_x;
    assign o_cursor_y      = n_pos_y;
    assign o_left_button   = n_left;
    assign o_right_button  = n_right;
    assign o_packet_status = w_status;

endmodule

// File: design/mouse_packet_cursor_tracker_unit.sv
// Mouse packet cursor tracker: top level with input and result registers.
// Instantiates mpct_cfg and mpct_tracker; depends on mpct_pkg.
//
// Usage:
//   Input channel (i_in_valid / o_in_stall) carries one controller byte or a
//   recenter request per transaction. Bytes flagged as mouse data build
//   three-byte packets; the third byte applies or rejects the packet.
//   Result channel (o_out_valid / i_out_stall) returns exactly one result per
//   input transaction: cursor position, buttons and packet status.
//   Configuration channel (i_cfg_valid / o_cfg_ready) writes speed mode,
//   screen width and screen height; write it only while the block is idle.
// Flow: an input is taken into the input register, and its result moves to the
//   result register once that is free or being emptied; it can then be taken.
//   Throughput: one transaction per cycle while the result is not stalled; the
//   next cursor state is computed combinationally between the two registers.
// Reset: cursor at 400,300, buttons released, packet phase cleared, speed
//   normal and an 800 by 600 screen. No result is pending after reset.
// Stall: while the result is held, one more transaction waits in the input
//   register; after that o_in_stall rises until the result is taken.
module mouse_packet_cursor_tracker_unit #(
    parameter int COORD_BITS = mpct_pkg::COORD_BITS_DEF
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_in_valid,
    output logic                         o_in_stall,
    input  logic                         i_operation,
    input  logic                         i_aux_ready,
    input  logic [7:0]                   i_data_byte,
    output logic                         o_out_valid,
    input  logic                         i_out_stall,
    output logic [COORD_BITS-1:0]        o_cursor_x,
    output logic [COORD_BITS-1:0]        o_cursor_y,
    output logic                         o_left_button,
    output logic                         o_right_button,
    output logic [1:0]                   o_packet_status,
    input  logic                         i_cfg_valid,
    output logic                         o_cfg_ready,
    input  logic [1:0]                   i_cfg_index,
    input  logic [mpct_pkg::SIZE_W-1:0]  i_cfg_data
);
    import mpct_pkg::*;

    logic                   r_s1_valid;
    logic                   r_op;
    logic                   r_aux;
    logic [7:0]             r_data;
    logic                   r_out_valid;
    logic [COORD_BITS-1:0]  r_x;
    logic [COORD_BITS-1:0]  r_y;
    logic                   r_left;
    logic                   r_right;
    t_status                r_status;

    logic                   w_in_take;
    logic                   w_advance;
    logic [SPEED_W-1:0]     w_speed;
    logic [COORD_BITS:0]    w_lim_x;
    logic [COORD_BITS:0]    w_lim_y;
    logic [COORD_BITS-1:0]  w_x;
    logic [COORD_BITS-1:0]  w_y;
    logic                   w_left;
    logic                   w_right;
    t_status                w_status;

    // Handshakes: advance when the result register is free or being emptied
    assign w_advance  = r_s1_valid && (!r_out_valid || !i_out_stall);
    assign o_in_stall = r_s1_valid && r_out_valid && i_out_stall;
    assign w_in_take  = i_in_valid && !o_in_stall;

    // Input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (w_in_take) begin
            r_s1_valid <= 1'b1;
        end else if (w_advance) begin
            r_s1_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_take) begin
            r_op   <= i_operation;
            r_aux  <= i_aux_ready;
            r_data <= i_data_byte;
        end
    end

    mpct_cfg #(
        .COORD_BITS (COORD_BITS)
    ) u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_speed     (w_speed),
        .o_lim_x     (w_lim_x),
        .o_lim_y     (w_lim_y)
    );

    mpct_tracker #(
        .COORD_BITS (COORD_BITS)
    ) u_tracker (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_take          (w_advance),
        .i_operation     (r_op),
        .i_aux_ready     (r_aux),
        .i_data_byte     (r_data),
        .i_speed         (w_speed),
        .i_lim_x         (w_lim_x),
        .i_lim_y         (w_lim_y),
        .o_cursor_x      (w_x),
        .o_cursor_y      (w_y),
        .o_left_button   (w_left),
        .o_right_button  (w_right),
        .o_packet_status (w_status)
    );

    // Result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_advance) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_advance) begin
            r_x      <= w_x;
            r_y      <= w_y;
            r_left   <= w_left;
            r_right  <= w_right;
            r_status <= w_status;
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_cursor_x      = r_x;
    assign o_cursor_y      = r_y;
    assign o_left_button   = r_left;
    assign o_right_button  = r_right;
    assign o_packet_status = r_status;

endmodule

// File: verif/tb_top.sv
// Self-checking testbench for mouse_packet_cursor_tracker_unit.
// Drives random and directed controller bytes, predicts every cursor report
// in SystemVerilog and compares each one as it leaves. Depends on mpct_pkg.
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import mpct_pkg::*;

    localparam int CB           = COORD_BITS_DEF;
    localparam int LIMIT_CYCLES = 200_000;
    localparam int LONG_HOLD    = 300;

    // One input transaction and one expected cursor report
    typedef struct packed {
        t_op        op;
        logic       aux;
        logic [7:0] data;
    } t_ctrl_byte;

    typedef struct packed {
        logic [CB-1:0] x;
        logic [CB-1:0] y;
        logic          left;
        logic          right;
        t_status       status;
    } t_cursor_report;

    // Block ports
    logic                 i_clk        = 1'b0;
    logic                 i_rst_n      = 1'b0;
    logic                 i_in_valid   = 1'b0;
    logic                 o_in_stall;
    t_op                  i_operation  = OP_BYTE;
    logic                 i_aux_ready  = 1'b0;
    logic [7:0]           i_data_byte  = 8'h00;
    logic                 o_out_valid;
    logic                 i_out_stall  = 1'b0;
    logic [CB-1:0]        o_cursor_x;
    logic [CB-1:0]        o_cursor_y;
    logic                 o_left_button;
    logic                 o_right_button;
    logic [1:0]           o_packet_status;
    logic                 i_cfg_valid  = 1'b0;
    logic                 o_cfg_ready;
    t_cfg_idx             i_cfg_index  = CFG_SPEED;
    logic [SIZE_W-1:0]    i_cfg_data   = '0;

    // Queues between stimulus, driver and checker
    t_ctrl_byte     byte_feed_q[$];
    t_cursor_report cursor_reports_q[$];

    // Predicted configuration and tracker state
    logic [SPEED_W-1:0] cfg_speed;
    logic [SIZE_W-1:0]  cfg_width;
    logic [SIZE_W-1:0]  cfg_height;
    logic [1:0]         pkt_phase;
    logic [7:0]         pkt_held[2];
    logic [CB-1:0]      pos_x;
    logic [CB-1:0]      pos_y;
    logic               left_held;
    logic               right_held;

    int mismatches  = 0;
    int cycle_count = 0;
    int burst_left  = 1;
    int gap_left    = 0;
    int stall_mode  = 0;
    int stall_left  = 0;
    int hold_left   = 0;
    int holds_asked = 0;
    int holds_done  = 0;

    mouse_packet_cursor_tracker_unit #(.COORD_BITS(CB)) uut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_in_valid      (i_in_valid),
        .o_in_stall      (o_in_stall),
        .i_operation     (i_operation),
        .i_aux_ready     (i_aux_ready),
        .i_data_byte     (i_data_byte),
        .o_out_valid     (o_out_valid),
        .i_out_stall     (i_out_stall),
        .o_cursor_x      (o_cursor_x),
        .o_cursor_y      (o_cursor_y),
        .o_left_button   (o_left_button),
        .o_right_button  (o_right_button),
        .o_packet_status (o_packet_status),
        .i_cfg_valid     (i_cfg_valid),
        .o_cfg_ready     (o_cfg_ready),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data)
    );

    always begin
        i_clk = 1'b1;
        #2;
        i_clk = 1'b0;
        #2;
    end

    // Effective screen limit: zero selects the default, never above the coordinate range
    function automatic int screen_limit(input logic [SIZE_W-1:0] size,
                                        input logic [SIZE_W-1:0] fallback);
        int lim;
        lim = (size == '0) ? int'(fallback) : int'(size);
        if (lim > (1 << CB)) begin
            lim = 1 << CB;
        end
        return lim;
    endfunction

    // Speed scaling; halving truncates toward zero, the unused code is normal
    function automatic int speed_scaled(input int d);
        if (cfg_speed == SPEED_HALF) begin
            return d / 2;
        end else if (cfg_speed == SPEED_DOUBLE) begin
            return d * 2;
        end
        return d;
    endfunction

    function automatic logic [CB-1:0] clamp_coord(input int v, input int lim);
        if (v < 0) begin
            v = 0;
        end
        if (v >= lim) begin
            v = lim - 1;
        end
        return v[CB-1:0];
    endfunction

    // Advance the predicted tracker by one transaction and build its report
    function automatic t_cursor_report track_cursor(input t_op op, input logic aux,
                                                    input logic [7:0] data);
        t_cursor_report rep;
        logic [7:0]     flags;
        int             dx;
        int             dy;
        rep.status = ST_NONE;
        if (op == OP_RECENTER) begin
            pos_x       = CB'(screen_limit(cfg_width, DEFAULT_W) / 2);
            pos_y       = CB'(screen_limit(cfg_height, DEFAULT_H) / 2);
            left_held   = 1'b0;
            right_held  = 1'b0;
            pkt_phase   = 2'd0;
            pkt_held[0] = 8'h00;
            pkt_held[1] = 8'h00;
        end else if (aux) begin
            if (pkt_phase < 2'd2) begin
                pkt_held[pkt_phase[0]] = data;
                pkt_phase = pkt_phase + 2'd1;
            end else begin
                pkt_phase = 2'd0;
                flags     = pkt_held[0];
                if (!flags[BIT_SYNC] || flags[BIT_X_OVF] || flags[BIT_Y_OVF]) begin
                    rep.status = ST_REJECTED;
                end else begin
                    dx = int'(pkt_held[1]);
                    dy = int'(data);
                    if (flags[BIT_X_SIGN]) begin
                        dx = dx - 256;
                    end
                    if (flags[BIT_Y_SIGN]) begin
                        dy = dy - 256;
                    end
                    dx = speed_scaled(dx);
                    dy = speed_scaled(dy);
                    // Screen Y grows downward, so subtract the movement
                    pos_x = clamp_coord(int'(pos_x) + dx, screen_limit(cfg_width, DEFAULT_W));
                    pos_y = clamp_coord(int'(pos_y) - dy, screen_limit(cfg_height, DEFAULT_H));
                    left_held  = flags[BIT_LEFT];
                    right_held = flags[BIT_RIGHT];
                    rep.status = ST_APPLIED;
                end
            end
        end
        rep.x     = pos_x;
        rep.y     = pos_y;
        rep.left  = left_held;
        rep.right = right_held;
        return rep;
    endfunction

    task automatic report_mismatch(input string what, input int got, input int want);
        $display("MISMATCH %s: got %0d, expected %0d at %0t", what, got, want, $realtime);
        mismatches++;
    endtask

    // Input driver: bursts of transactions separated by random gaps
    always @(posedge i_clk) begin : feed_proc
        t_ctrl_byte nxt;
        logic       free_slot;
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else begin
            free_slot = !i_in_valid;
            if (i_in_valid && !o_in_stall) begin
                cursor_reports_q.push_back(track_cursor(i_operation, i_aux_ready, i_data_byte));
                free_slot = 1'b1;
            end
            if (free_slot) begin
                if (gap_left > 0) begin
                    gap_left--;
                    i_in_valid <= 1'b0;
                end else if (byte_feed_q.size() > 0) begin
                    nxt = byte_feed_q.pop_front();
                    i_operation <= nxt.op;
                    i_aux_ready <= nxt.aux;
                    i_data_byte <= nxt.data;
                    i_in_valid  <= 1'b1;
                    if (burst_left > 1) begin
                        burst_left--;
                    end else begin
                        burst_left = $urandom_range(1, 40);
                        gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
                    end
                end else begin
                    i_in_valid <= 1'b0;
                end
            end
        end
    end

    // Result stall: random modes of varying density, plus requested long hold-offs
    always @(posedge i_clk) begin : stall_proc
        if (!i_rst_n) begin
            i_out_stall <= 1'b0;
        end else if (hold_left > 0) begin
            hold_left--;
            i_out_stall <= 1'b1;
        end else if (holds_done != holds_asked) begin
            holds_done++;
            hold_left = LONG_HOLD;
            i_out_stall <= 1'b1;
        end else begin
            if (stall_left == 0) begin
                stall_mode = $urandom_range(0, 2);
                stall_left = $urandom_range(10, 60);
            end else begin
                stall_left--;
            end
            case (stall_mode)
                0:       i_out_stall <= 1'b0;
                1:       i_out_stall <= ($urandom_range(0, 3) == 0);
                default: i_out_stall <= ($urandom_range(0, 3) != 0);
            endcase
        end
    end

    // Result checker: compare each transaction with the oldest prediction
    always @(posedge i_clk) begin : check_proc
        t_cursor_report want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (cursor_reports_q.size() == 0) begin
                report_mismatch("unexpected result, status", int'(o_packet_status), -1);
            end else begin
                want = cursor_reports_q.pop_front();
                if (o_cursor_x !== want.x) begin
                    report_mismatch("cursor_x", int'(o_cursor_x), int'(want.x));
                end
                if (o_cursor_y !== want.y) begin
                    report_mismatch("cursor_y", int'(o_cursor_y), int'(want.y));
                end
                if (o_left_button !== want.left) begin
                    report_mismatch("left_button", int'(o_left_button), int'(want.left));
                end
                if (o_right_button !== want.right) begin
                    report_mismatch("right_button", int'(o_right_button), int'(want.right));
                end
                if (o_packet_status !== want.status) begin
                    report_mismatch("packet_status", int'(o_packet_status), int'(want.status));
                end
            end
        end
    end

    // Watchdog
    always @(posedge i_clk) begin : watchdog_proc
        cycle_count <= cycle_count + 1;
        if (cycle_count >= LIMIT_CYCLES) begin
            $display("tb_top failed");
            $finish;
        end
    end

    task automatic queue_byte(input t_op op, input logic aux, input logic [7:0] data);
        t_ctrl_byte b;
        b.op   = op;
        b.aux  = aux;
        b.data = data;
        byte_feed_q.push_back(b);
    endtask

    task automatic queue_packet(input logic [7:0] flags, input logic [7:0] bx,
                                input logic [7:0] by);
        queue_byte(OP_BYTE, 1'b1, flags);
        queue_byte(OP_BYTE, 1'b1, bx);
        queue_byte(OP_BYTE, 1'b1, by);
    endtask

    // Mostly well-formed packets, with noise bytes, recenters and stray bytes
    task automatic queue_traffic(input int count);
        int         added;
        int         pick;
        logic [7:0] flags;
        added = 0;
        while (added < count) begin
            pick = $urandom_range(0, 99);
            if (pick < 75) begin
                flags = 8'($urandom);
                if ($urandom_range(0, 9) != 0) begin
                    flags[BIT_SYNC] = 1'b1;
                end
                if ($urandom_range(0, 7) != 0) begin
                    flags[BIT_Y_OVF:BIT_X_OVF] = 2'b00;
                end
                queue_byte(OP_BYTE, 1'b1, flags);
                if ($urandom_range(0, 9) == 0) begin
                    queue_byte(OP_BYTE, 1'b0, 8'($urandom));
                    added++;
                end
                queue_byte(OP_BYTE, 1'b1, 8'($urandom));
                queue_byte(OP_BYTE, 1'b1, 8'($urandom));
                added += 3;
            end else if (pick < 85) begin
                queue_byte(OP_BYTE, 1'b0, 8'($urandom));
                added++;
            end else if (pick < 90) begin
                queue_byte(OP_RECENTER, 1'($urandom), 8'($urandom));
                added++;
            end else begin
                queue_byte(OP_BYTE, 1'b1, 8'($urandom));
                added++;
            end
        end
    endtask

    // Hold until every transaction is sent and every report has been checked
    task automatic wait_drained();
        while (byte_feed_q.size() != 0 || i_in_valid || cursor_reports_q.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (6) @(posedge i_clk);
    endtask

    task automatic write_reg(input t_cfg_idx idx, input logic [SIZE_W-1:0] val);
        @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        @(posedge i_clk);
        while (!o_cfg_ready) begin
            @(posedge i_clk);
        end
        case (idx)
            CFG_SPEED:  cfg_speed  = val[SPEED_W-1:0];
            CFG_WIDTH:  cfg_width  = val;
            CFG_HEIGHT: cfg_height = val;
            default:    ;
        endcase
        i_cfg_valid <= 1'b0;
    endtask

    task automatic configure(input logic [SIZE_W-1:0] speed, input logic [SIZE_W-1:0] w,
                             input logic [SIZE_W-1:0] h);
        wait_drained();
        write_reg(CFG_SPEED, speed);
        write_reg(CFG_WIDTH, w);
        write_reg(CFG_HEIGHT, h);
    endtask

    initial begin
        // Predicted state after reset
        cfg_speed   = SPEED_NORMAL;
        cfg_width   = DEFAULT_W;
        cfg_height  = DEFAULT_H;
        pkt_phase   = 2'd0;
        pkt_held[0] = 8'h00;
        pkt_held[1] = 8'h00;
        pos_x       = CB'(RESET_X);
        pos_y       = CB'(RESET_Y);
        left_held   = 1'b0;
        right_held  = 1'b0;

        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: ignored byte, signed moves, clamping, rejects, recenter mid-packet
        queue_byte(OP_BYTE, 1'b0, 8'hFF);
        queue_packet(8'h08, 8'hFF, 8'h00);
        queue_packet(8'h3B, 8'h01, 8'h00);
        queue_packet(8'h28, 8'h00, 8'h80);
        queue_byte(OP_BYTE, 1'b1, 8'h0A);
        queue_byte(OP_BYTE, 1'b0, 8'h5A);
        queue_byte(OP_BYTE, 1'b1, 8'hFF);
        queue_byte(OP_BYTE, 1'b1, 8'h7F);
        queue_packet(8'h00, 8'h55, 8'hAA);
        queue_packet(8'hC8, 8'h10, 8'h10);
        queue_byte(OP_BYTE, 1'b1, 8'h09);
        queue_byte(OP_RECENTER, 1'b1, 8'hA5);
        queue_packet(8'h19, 8'h00, 8'h00);
        queue_byte(OP_RECENTER, 1'b0, 8'h00);
        queue_traffic(80);

        // Largest screen at double speed, with a long result hold-off
        configure(12'(SPEED_DOUBLE), 12'd4095, 12'd4095);
        queue_packet(8'h08, 8'hFF, 8'h80);
        holds_asked <= holds_asked + 1;
        queue_traffic(95);

        // Zero sizes fall back to the defaults, half speed
        configure(12'(SPEED_HALF), 12'd0, 12'd0);
        queue_byte(OP_RECENTER, 1'b0, 8'h00);
        queue_packet(8'h38, 8'hFF, 8'hFF);
        queue_packet(8'h18, 8'h01, 8'h01);
        queue_traffic(90);

        // Unused speed code on a one-pixel screen
        configure(12'd3, 12'd1, 12'd1);
        queue_packet(8'h08, 8'h40, 8'h40);
        queue_traffic(80);

        // Random screen size, normal speed
        configure(12'(SPEED_NORMAL), 12'($urandom_range(1, 4095)),
                  12'($urandom_range(1, 4095)));
        queue_byte(OP_RECENTER, 1'b1, 8'h00);
        queue_traffic(95);

        wait_drained();
        if (mismatches == 0) begin
            $display("tb_top passed");
        end else begin
            $display("tb_top failed");
        end
        $finish;
    end

endmodule

// File: mouse_packet_cursor_tracker_unit.f
design/mpct_pkg.sv
design/mpct_cfg.sv
design/mpct_tracker.sv
design/mouse_packet_cursor_tracker_unit.sv
verif/tb_top.sv
